[src/pidaw_pkg.sv]
// Shared types, constants and helpers for the PID controller with integrator clamp.
package pidaw_pkg;

   localparam int HISTORY_DEPTH_DEFAULT = 4;

   localparam int DATA_W      = 32;
   localparam int INTEG_W     = 48;
   localparam int PROD_W      = 64;
   localparam int TERM_W      = 80;
   localparam int DIVD_W      = 49;
   localparam int DIVS_W      = 40;
   localparam int CSR_INDEX_W = 3;

   // |integ_gain| must exceed this before the clamp applies (about 0.0001 in Q16.16)
   localparam logic [31:0] KI_THRESHOLD = 32'd6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DERIV_GAIN    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDUP_LIMIT  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET        = 3'd5;

   // operand pair fed to the shared multiplier
   typedef enum logic [2:0] {
      MS_ERR_SP,
      MS_KP_ERR,
      MS_KD_DER,
      MS_KI_ILO,
      MS_KI_IHI
   } mul_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        hist_write;
      logic        hist_clear;
      logic        mul_go;
      mul_sel_type mul_sel;
      logic        integ_add;
      logic        div_start_k;
      logic        clamp_apply;
      logic        mem_rd;
      logic        div_start_d;
      logic        deriv_zero;
      logic        deriv_load;
      logic        acc_clr;
      logic        acc_add;
      logic        term_load;
      logic        term_addhi;
      logic        acc_add_term;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic op_reset;
      logic ki_big;
      logic den_zero;
      logic div_busy;
      logic div_done;
   } status_type;

   function automatic logic [31:0] abs32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [47:0] abs48(input logic [47:0] v);
      return v[47] ? (~v + 48'd1) : v;
   endfunction

endpackage

[src/pidaw_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module pidaw_div #(
   parameter int N = pidaw_pkg::DIVD_W,
   parameter int V = pidaw_pkg::DIVS_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [N-1:0] dividend,
   input  logic [V-1:0] divisor,
   output logic         busy,
   output logic         done,
   output logic [N-1:0] quot
);

   localparam int CNT_W = $clog2(N + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [V-1:0]     rem_ff, rem_in;
   logic [N-1:0]     qd_ff, qd_in;
   logic [V-1:0]     dvs_ff, dvs_in;

   logic [V:0] shifted;
   logic [V:0] diff;
   logic       fit;

   // one trial subtraction
   always_comb begin
      shifted = {rem_ff, qd_ff[N-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fit     = shifted >= {1'b0, dvs_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      qd_in   = qd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(N);
         rem_in  = '0;
         qd_in   = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fit ? diff[V-1:0] : shifted[V-1:0];
         qd_in  = {qd_ff[N-2:0], fit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      qd_ff  <= qd_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = qd_ff;

endmodule

[src/pidaw_dp.sv]
// Datapath: registers, error history, shared multiplier, divider and accumulator.
module pidaw_dp #(
   parameter int HISTORY_DEPTH = pidaw_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  pidaw_pkg::cmd_type                  cmd,
   output pidaw_pkg::status_type               stat,
   input  logic                                req_op,
   input  logic signed [31:0]                  req_measured,
   input  logic                                csr_we,
   input  logic [pidaw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                         csr_data,
   output logic signed [31:0]                  rsp_drive
);

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
   localparam int DW = pidaw_pkg::DIVD_W;
   localparam int VW = pidaw_pkg::DIVS_W;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   // configuration registers
   logic [31:0] kp_ff, ki_ff, kd_ff, tgt_ff;
   logic [30:0] sp_ff, wl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff  <= '0;
         ki_ff  <= '0;
         kd_ff  <= '0;
         sp_ff  <= 31'd65536;
         wl_ff  <= 31'h7FFF_FFFF;
         tgt_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pidaw_pkg::CSR_PROP_GAIN:     kp_ff  <= csr_data;
            pidaw_pkg::CSR_INTEG_GAIN:    ki_ff  <= csr_data;
            pidaw_pkg::CSR_DERIV_GAIN:    kd_ff  <= csr_data;
            pidaw_pkg::CSR_SAMPLE_PERIOD: sp_ff  <= csr_data[30:0];
            pidaw_pkg::CSR_WINDUP_LIMIT:  wl_ff  <= csr_data[30:0];
            pidaw_pkg::CSR_TARGET:        tgt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // captured item
   logic        op_ff;
   logic [31:0] meas_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_op;
         meas_ff <= req_measured;
      end
   end

   // controller state and working registers
   logic [31:0]              err_ff, err_in;
   logic [47:0]              integ_ff, integ_in;
   logic [PTR_W-1:0]         ptr_ff;
   logic [HISTORY_DEPTH-1:0] vld_ff;
   logic [31:0]              mem [HISTORY_DEPTH];
   logic [31:0]              rd_ff;
   logic                     rdv_ff;
   logic [63:0]              prod_ff;
   logic                     neg_ff;
   logic [79:0]              term_ff;
   logic [63:0]              acc_ff, acc_in;
   logic [31:0]              deriv_ff, deriv_in;
   logic                     num_neg_ff;
   logic [31:0]              drive_ff;

   logic [31:0] kp_mag, ki_mag, kd_mag, err_mag, der_mag;
   logic [47:0] integ_mag;

   always_comb begin
      kp_mag    = pidaw_pkg::abs32(kp_ff);
      ki_mag    = pidaw_pkg::abs32(ki_ff);
      kd_mag    = pidaw_pkg::abs32(kd_ff);
      err_mag   = pidaw_pkg::abs32(err_ff);
      der_mag   = pidaw_pkg::abs32(deriv_ff);
      integ_mag = pidaw_pkg::abs48(integ_ff);
   end

   // saturated error of the new sample
   logic [32:0] diff33;
   logic [31:0] err_new;

   always_comb begin
      diff33 = {tgt_ff[31], tgt_ff} - {meas_ff[31], meas_ff};
      if (diff33[32] != diff33[31]) begin
         err_new = diff33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
         err_new = diff33[31:0];
      end
   end

   // shared divider: clamp bound or derivative
   logic          div_start, div_busy, div_done;
   logic [DW-1:0] div_dvd, div_quot;
   logic [VW-1:0] div_dvs;
   logic [39:0]   den;
   logic [32:0]   num, num_mag;
   logic [31:0]   oldest;

   always_comb begin
      den     = 40'(sp_ff) * 40'(HISTORY_DEPTH);
      oldest  = rdv_ff ? rd_ff : 32'd0;
      num     = {err_ff[31], err_ff} - {oldest[31], oldest};
      num_mag = num[32] ? (~num + 33'd1) : num;
      div_start = cmd.div_start_k | cmd.div_start_d;
      if (cmd.div_start_k) begin
         div_dvd = DW'({wl_ff, 16'd0});
         div_dvs = VW'(ki_mag);
      end else begin
         div_dvd = DW'({num_mag, 16'd0});
         div_dvs = VW'(den);
      end
   end

   pidaw_div #(.N(DW), .V(VW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot)
   );

   // integrator update, clamp and error
   logic [47:0] p48;
   logic [49:0] isum;

   always_comb begin
      p48      = prod_ff[63:16];
      isum     = {{2{integ_ff[47]}}, integ_ff}
               + (neg_ff ? (~{2'b00, p48} + 50'd1) : {2'b00, p48});
      integ_in = integ_ff;
      err_in   = err_ff;
      if (cmd.hist_write) begin
         err_in = err_new;
      end
      if (cmd.hist_clear) begin
         integ_in = '0;
      end else if (cmd.integ_add) begin
         if (isum[49:47] == 3'b000 || isum[49:47] == 3'b111) begin
            integ_in = isum[47:0];
         end else begin
            integ_in = isum[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
         end
      end else if (cmd.clamp_apply) begin
         if ({1'b0, integ_mag} > div_quot) begin
            integ_in = integ_ff[47] ? (~div_quot[47:0] + 48'd1) : div_quot[47:0];
         end
      end
   end

   // derivative from the divider quotient, saturated
   always_comb begin
      deriv_in = deriv_ff;
      if (cmd.deriv_zero) begin
         deriv_in = '0;
      end else if (cmd.deriv_load) begin
         if (num_neg_ff) begin
            deriv_in = (div_quot > DW'(33'h0_8000_0000)) ? 32'h8000_0000
                                                         : (~div_quot[31:0] + 32'd1);
         end else begin
            deriv_in = (div_quot > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_quot[31:0];
         end
      end
   end

   // multiplier operands and product sign
   logic [31:0] mul_a, mul_b;
   logic        mul_neg;

   always_comb begin
      case (cmd.mul_sel)
         pidaw_pkg::MS_ERR_SP: begin
            mul_a = err_mag;  mul_b = {1'b0, sp_ff};        mul_neg = err_ff[31];
         end
         pidaw_pkg::MS_KP_ERR: begin
            mul_a = kp_mag;   mul_b = err_mag;  mul_neg = kp_ff[31] ^ err_ff[31];
         end
         pidaw_pkg::MS_KD_DER: begin
            mul_a = kd_mag;   mul_b = der_mag;  mul_neg = kd_ff[31] ^ deriv_ff[31];
         end
         pidaw_pkg::MS_KI_ILO: begin
            mul_a = ki_mag;   mul_b = integ_mag[31:0];
            mul_neg = ki_ff[31] ^ integ_ff[47];
         end
         pidaw_pkg::MS_KI_IHI: begin
            mul_a = ki_mag;   mul_b = {16'd0, integ_mag[47:32]};
            mul_neg = ki_ff[31] ^ integ_ff[47];
         end
         default: begin
            mul_a = '0;       mul_b = '0;       mul_neg = 1'b0;
         end
      endcase
   end

   // output accumulator
   logic [63:0] acc_term;

   always_comb begin
      acc_term = 64'd0;
      if (cmd.acc_add) begin
         acc_term = {16'd0, prod_ff[63:16]};
      end else if (cmd.acc_add_term) begin
         acc_term = term_ff[79:16];
      end
      acc_in = acc_ff;
      if (cmd.acc_clr) begin
         acc_in = '0;
      end else if (cmd.acc_add || cmd.acc_add_term) begin
         acc_in = acc_ff + (neg_ff ? (~acc_term + 64'd1) : acc_term);
      end
   end

   // history and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff   <= '0;
         integ_ff <= '0;
         ptr_ff   <= PTR_LAST;
         vld_ff   <= '0;
      end else begin
         err_ff   <= err_in;
         integ_ff <= integ_in;
         if (cmd.hist_clear) begin
            vld_ff <= '0;
         end else if (cmd.hist_write) begin
            ptr_ff                   <= ptr_next(ptr_ff);
            vld_ff[ptr_next(ptr_ff)] <= 1'b1;
         end
      end
   end

   // history memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.hist_write) begin
         mem[ptr_next(ptr_ff)] <= err_ff;
      end
      if (cmd.mem_rd) begin
         rd_ff  <= mem[ptr_next(ptr_ff)];
         rdv_ff <= vld_ff[ptr_next(ptr_ff)];
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
         neg_ff  <= mul_neg;
      end
      if (cmd.term_load) begin
         term_ff <= 80'(prod_ff);
      end else if (cmd.term_addhi) begin
         term_ff <= term_ff + (80'(prod_ff) << 32);
      end
      if (cmd.div_start_d) begin
         num_neg_ff <= num[32];
      end
      deriv_ff <= deriv_in;
      acc_ff   <= acc_in;
      if (cmd.out_load) begin
         if (acc_ff[63:31] == '0 || acc_ff[63:31] == '1) begin
            drive_ff <= acc_ff[31:0];
         end else begin
            drive_ff <= acc_ff[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end
      end
   end

   always_comb begin
      stat.op_reset = op_ff;
      stat.ki_big   = ki_mag > pidaw_pkg::KI_THRESHOLD;
      stat.den_zero = (sp_ff == '0);
      stat.div_busy = div_busy;
      stat.div_done = div_done;
   end

   assign rsp_drive = drive_ff;

endmodule

[src/pidaw_ctrl.sv]
// Sequencer: steps the datapath through one item and runs both handshakes.
module pidaw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pidaw_pkg::status_type stat,
   output pidaw_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL_ESP,
      ST_INTEG,
      ST_CLAMP_CHK,
      ST_CLAMP_WAIT,
      ST_RDMEM,
      ST_DERIV,
      ST_DERIV_WAIT,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_KL,
      ST_MUL_KH,
      ST_TERM_H,
      ST_ACC_K,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // next state and command decode
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = pidaw_pkg::MS_ERR_SP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.op_reset) begin
               cmd.hist_clear = 1'b1;
               state_in       = ST_RDMEM;
            end else begin
               cmd.hist_write = 1'b1;
               state_in       = ST_MUL_ESP;
            end
         end
         ST_MUL_ESP: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = pidaw_pkg::MS_ERR_SP;
            state_in    = ST_INTEG;
         end
         ST_INTEG: begin
            cmd.integ_add = 1'b1;
            state_in      = ST_CLAMP_CHK;
         end
         ST_CLAMP_CHK: begin
            if (stat.ki_big) begin
               cmd.div_start_k = 1'b1;
               state_in        = ST_CLAMP_WAIT;
            end else begin
               state_in = ST_RDMEM;
            end
         end
         ST_CLAMP_WAIT: begin
            if (stat.div_done) begin
               cmd.clamp_apply = 1'b1;
               state_in        = ST_RDMEM;
            end
         end
         ST_RDMEM: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_DERIV;
         end
         ST_DERIV: begin
            if (stat.den_zero) begin
               cmd.deriv_zero = 1'b1;
               state_in       = ST_MUL_P;
            end else begin
               cmd.div_start_d = 1'b1;
               state_in        = ST_DERIV_WAIT;
            end
         end
         ST_DERIV_WAIT: begin
            if (stat.div_done) begin
               cmd.deriv_load = 1'b1;
               state_in       = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = pidaw_pkg::MS_KP_ERR;
            cmd.acc_clr = 1'b1;
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = pidaw_pkg::MS_KD_DER;
            cmd.acc_add = 1'b1;
            state_in    = ST_MUL_KL;
         end
         ST_MUL_KL: begin
            cmd.mul_go  = 1'b1;
            cmd.mul_sel = pidaw_pkg::MS_KI_ILO;
            cmd.acc_add = 1'b1;
            state_in    = ST_MUL_KH;
         end
         ST_MUL_KH: begin
            cmd.mul_go    = 1'b1;
            cmd.mul_sel   = pidaw_pkg::MS_KI_IHI;
            cmd.term_load = 1'b1;
            state_in      = ST_TERM_H;
         end
         ST_TERM_H: begin
            cmd.term_addhi = 1'b1;
            state_in       = ST_ACC_K;
         end
         ST_ACC_K: begin
            cmd.acc_add_term = 1'b1;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            // wait until the output register is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[src/pid_controller_antiwindup_top.sv]
// An update passes through the divider once for the derivative when the sample period is
// nonzero, and once more for the clamp bound when |integ_gain| is above threshold;
// a reset item skips the clamp.
// One item at a time: the next is accepted once the sequencer is idle again, and later
// while a result waits on stall.
// Synchronous reset: registers, integrator, error and history clear (history via valid bits).
module pid_controller_antiwindup_top #(
   parameter int HISTORY_DEPTH = pidaw_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic signed [31:0]                req_measured,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_drive,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pidaw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                       csr_data
);

   pidaw_pkg::cmd_type    cmd;
   pidaw_pkg::status_type stat;
   logic                  csr_we;

   // registers accept a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   pidaw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pidaw_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_op       (req_op),
      .req_measured (req_measured),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_drive    (rsp_drive)
   );

   // an accepted item makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after an item was accepted");

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid && rsp_stall))
      else $error("result loaded over one still waiting");

   // the divider is started only when free
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_start_k || cmd.div_start_d) |-> !stat.div_busy)
      else $error("divider started while busy");

endmodule
